// ===== hw/rtl/itr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itr_pkg: shared definitions for the idle target ratio block
// Field widths, register indexes, reset values and sequencer codes.
// ----------------------------------------------------------------------------
package itr_pkg;

    // Default number of fraction bits of the ratio and the peak.
    localparam int RATIO_FRAC_BITS_DEF = 16;

    // Widths of the item fields.
    localparam int ROTOR_W   = 8;
    localparam int RPM_W     = 16;
    localparam int COOLANT_W = 16;
    localparam int REF_W     = 32;
    localparam int TARGET_W  = 32;
    localparam int HOLD_W    = 8;

    // Packed stream widths, padded to whole bytes.
    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 72;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RPM_THRESHOLD = 2'd0,
        CFG_HOLD_RELOAD   = 2'd1
    } cfg_index_t;

    // Register reset values.
    localparam logic [RPM_W-1:0]  RPM_THRESHOLD_RST = 16'd2500;
    localparam logic [HOLD_W-1:0] HOLD_RELOAD_RST   = 8'hFF;

    // Saturation limits of the target.
    localparam logic [TARGET_W-1:0] TARGET_MAX = 32'h7FFF_FFFF;
    localparam logic [TARGET_W-1:0] TARGET_MIN = 32'h8000_0000;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_SAT  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

endpackage

// ===== hw/rtl/idle_target_ratio_with_peak_hold.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idle_target_ratio_with_peak_hold: idle target ratio with a held peak
// Computes (alt - main) / main in fixed point with one shared restoring
// divider step, runs the rotor-edge hold counter and the peak register.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_tvalid / s_tready / s_tdata, one per control tick.
//   Each item gives exactly one result on m_tvalid / m_tready / m_tdata.
//   cfg_ready is always high. The user writes the two registers through cfg_valid /
//   cfg_ready / cfg_index / cfg_data only while no item is in flight (not enforced).
// Sequence:
//   When the ratio is needed and the divisor is nonzero, an accepted item goes
//   through ST_DIV, where the divider runs one quotient bit a cycle over
//   16 + RATIO_FRAC_BITS bits, then through ST_SAT and ST_FIN; otherwise it goes
//   straight to ST_FIN. A new item is accepted only once the sequencer is back
//   in ST_IDLE, after the last result has moved into the output register.
// Reset and stall:
//   rst_n clears the rotor history, the hold counter, the peak and the output
//   valid flag, and loads the register defaults. A finished result waits in
//   the output register while m_tready is low; the next item is accepted
//   meanwhile and waits at its last step until the output register is free.
// ----------------------------------------------------------------------------
module idle_target_ratio_with_peak_hold
    import itr_pkg::*;
#(
    parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // From bit 0: rotor_a_status[8], rotor_b_status[8], engine_rpm[16],
    // engine_running[1], closed_loop_active[1], main_temp[16],
    // alt_temp[16], reference_one[32], reference_two[32], zero pad[6]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // Result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // From bit 0: target[32], hold_count[8], peak_value[32]
    output logic [OUT_DATA_W-1:0] m_tdata
);

    // Numerator magnitude is |alt - main| (16 bits) scaled by the fraction.
    localparam int NUM_W = COOLANT_W + RATIO_FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W);
    localparam int EXT_W = (NUM_W > TARGET_W + 1) ? NUM_W : TARGET_W + 1;

    // Configuration registers
    logic [RPM_W-1:0]  rpm_threshold_reg;
    logic [HOLD_W-1:0] hold_reload_reg;

    // Sequencer and divider
    state_t              state_reg, state_next;
    logic [NUM_W-1:0]    quo_reg;
    logic [COOLANT_W-1:0] rem_reg;
    logic [COOLANT_W-1:0] div_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                neg_reg;

    // Captured item
    logic [ROTOR_W-1:0]  rotor_a_reg, rotor_b_reg;
    logic                clear_ok_reg;
    logic [TARGET_W-1:0] target_reg;

    // Persistent block state
    logic [ROTOR_W-1:0]  prev_a_reg, prev_b_reg;
    logic [HOLD_W-1:0]   hold_reg;
    logic [TARGET_W-1:0] peak_reg;

    // Output register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    // Unpacked input fields
    logic [ROTOR_W-1:0]   in_rotor_a, in_rotor_b;
    logic [RPM_W-1:0]     in_rpm;
    logic                 in_running, in_closed;
    logic [COOLANT_W-1:0] in_main, in_alt;
    logic [REF_W-1:0]     in_ref_one, in_ref_two;

    assign in_rotor_a = s_tdata[7:0];
    assign in_rotor_b = s_tdata[15:8];
    assign in_rpm     = s_tdata[31:16];
    assign in_running = s_tdata[32];
    assign in_closed  = s_tdata[33];
    assign in_main    = s_tdata[49:34];
    assign in_alt     = s_tdata[65:50];
    assign in_ref_one = s_tdata[97:66];
    assign in_ref_two = s_tdata[129:98];

    // Handshakes
    logic in_fire;
    logic out_free;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Front end: difference, magnitudes and the special cases of the ratio.
    logic signed [COOLANT_W:0] diff;
    logic [COOLANT_W-1:0]      diff_mag;
    logic [COOLANT_W-1:0]      main_mag;
    logic                      ratio_en;
    logic                      main_zero;
    logic                      ref_one_pos, ref_two_pos;
    logic [TARGET_W-1:0]       early_target;

    always_comb
    begin
        diff        = $signed({in_alt[COOLANT_W-1], in_alt})
                    - $signed({in_main[COOLANT_W-1], in_main});
        diff_mag    = diff[COOLANT_W] ? COOLANT_W'(-diff) : diff[COOLANT_W-1:0];
        main_mag    = in_main[COOLANT_W-1] ? (~in_main + 1'b1) : in_main;
        ratio_en    = !in_running && !in_closed && (in_rpm >= rpm_threshold_reg);
        main_zero   = (in_main == '0);
        ref_one_pos = !in_ref_one[REF_W-1] && (in_ref_one != '0);
        ref_two_pos = !in_ref_two[REF_W-1] && (in_ref_two != '0);
        if (!ratio_en || diff == '0)
        begin
            early_target = '0;
        end
        else if (diff[COOLANT_W])
        begin
            early_target = TARGET_MIN;
        end
        else
        begin
            early_target = TARGET_MAX;
        end
    end

    // Shared divider step: shift one numerator bit in and trial-subtract.
    logic [COOLANT_W:0]   rem_shift;
    logic [COOLANT_W+1:0] trial;
    logic                 q_bit;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[NUM_W-1]};
        trial     = {1'b0, rem_shift} - {2'b00, div_reg};
        q_bit     = !trial[COOLANT_W+1];
    end

    // Signed saturation of the quotient magnitude.
    logic [EXT_W-1:0]    q_ext;
    logic [TARGET_W-1:0] sat_target;

    always_comb
    begin
        q_ext = EXT_W'(quo_reg);
        if (!neg_reg)
        begin
            sat_target = (q_ext > EXT_W'(TARGET_MAX)) ? TARGET_MAX : q_ext[TARGET_W-1:0];
        end
        else
        begin
            sat_target = (q_ext > EXT_W'(TARGET_MIN)) ? TARGET_MIN
                       : (~q_ext[TARGET_W-1:0] + 1'b1);
        end
    end

    // Hold counter and peak update for the finishing item.
    logic                edge_seen;
    logic [HOLD_W-1:0]   hold_next;
    logic [TARGET_W-1:0] peak_next;

    always_comb
    begin
        edge_seen = (prev_a_reg == ROTOR_W'(1) && rotor_a_reg == '0)
                 || (prev_b_reg == ROTOR_W'(1) && rotor_b_reg == '0);
        if (edge_seen)
        begin
            hold_next = hold_reload_reg;
        end
        else if (hold_reg != '0)
        begin
            hold_next = hold_reg - 1'b1;
        end
        else
        begin
            hold_next = hold_reg;
        end

        peak_next = peak_reg;
        if (hold_next != '0)
        begin
            if ($signed(target_reg) > $signed(peak_reg))
            begin
                peak_next = target_reg;
            end
        end
        else if (clear_ok_reg)
        begin
            peak_next = '0;
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (ratio_en && !main_zero) ? ST_DIV : ST_FIN;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            rpm_threshold_reg <= RPM_THRESHOLD_RST;
            hold_reload_reg   <= HOLD_RELOAD_RST;
            prev_a_reg        <= '0;
            prev_b_reg        <= '0;
            hold_reg          <= '0;
            peak_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_RPM_THRESHOLD)
                begin
                    rpm_threshold_reg <= cfg_data[RPM_W-1:0];
                end
                else if (cfg_index == CFG_HOLD_RELOAD)
                begin
                    hold_reload_reg <= cfg_data[HOLD_W-1:0];
                end
            end

            if (state_reg == ST_FIN && out_free)
            begin
                prev_a_reg    <= rotor_a_reg;
                prev_b_reg    <= rotor_b_reg;
                hold_reg      <= hold_next;
                peak_reg      <= peak_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    rotor_a_reg  <= in_rotor_a;
                    rotor_b_reg  <= in_rotor_b;
                    clear_ok_reg <= !ref_one_pos && !ref_two_pos;
                    target_reg   <= early_target;
                    quo_reg      <= {diff_mag, {RATIO_FRAC_BITS{1'b0}}};
                    rem_reg      <= '0;
                    div_reg      <= main_mag;
                    neg_reg      <= diff[COOLANT_W] ^ in_main[COOLANT_W-1];
                    cnt_reg      <= CNT_W'(NUM_W - 1);
                end
            end
            ST_DIV:
            begin
                rem_reg <= q_bit ? trial[COOLANT_W-1:0] : rem_shift[COOLANT_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], q_bit};
                cnt_reg <= cnt_reg - 1'b1;
            end
            ST_SAT:
            begin
                target_reg <= sat_target;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_data_reg <= {peak_next, hold_next, target_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== hw/rtl/itr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itr_checker: port-level checks for the idle target ratio block
// Watches the item channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module itr_checker
    import itr_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // The block works on one item at a time, so it drops ready after taking one.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("input ready stayed high after an item was accepted");

    // While the hold counter runs, the peak is never below the current target.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[39:32] != '0)
            |-> $signed(m_tdata[71:40]) >= $signed(m_tdata[31:0]))
    else $error("peak below target while the hold counter is running");

    // A pending result is not withdrawn.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
    else $error("result valid dropped before it was taken");

    // A pending result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result payload changed while stalled");

endmodule

bind idle_target_ratio_with_peak_hold itr_checker u_itr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
